FILE: src/pli_pkg.sv
// Package for the positional list block: sizes, status codes, the command
// word passed from front to back, and the back-end state type.
// No dependencies.
`default_nettype none

package pli_pkg;

    localparam int CAPACITY = 32;
    localparam int LEN_W    = $clog2(CAPACITY + 1);
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int POS_W    = 6;
    localparam int VAL_W    = 32;
    localparam int IDX_W    = 5;
    localparam int Q_DEPTH  = 2;
    localparam int Q_AW     = $clog2(Q_DEPTH);
    localparam int Q_CW     = $clog2(Q_DEPTH + 1);

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic             op;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] value;
        t_status          status;
        logic [LEN_W-1:0] old_len;
        logic [LEN_W-1:0] new_len;
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MOVE,
        S_PUT,
        S_DUMP
    } t_back_state;

endpackage

`default_nettype wire

FILE: src/pli_front.sv
// Front end of the positional list: checks each word against a shadow copy
// of the list length and builds the command word for the queue.
// Depends on pli_pkg.
`default_nettype none

module pli_front (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic                      i_full,
    input  wire logic                      i_operation,
    input  wire logic [pli_pkg::POS_W-1:0] i_position,
    input  wire logic [pli_pkg::VAL_W-1:0] i_value,
    output logic                           o_push,
    output pli_pkg::t_cmd                  o_cmd
);
    import pli_pkg::*;

    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] n_len;
    logic [LEN_W-1:0] cap_len;
    t_status          status;

    assign cap_len = LEN_W'(CAPACITY);
    assign o_push  = i_start && !i_full;

    // The length only moves by one, and only on a successful operation.
    always_comb begin
        status = ST_DONE;
        n_len  = r_len;
        if (i_operation == OP_INSERT) begin
            if ({1'b0, i_position} > {1'b0, r_len}) begin
                status = ST_RANGE;
            end else if (r_len >= cap_len) begin
                status = ST_FULL;
            end else begin
                n_len = r_len + LEN_W'(1);
            end
        end else begin
            if ({1'b0, i_position} >= {1'b0, r_len}) begin
                status = ST_RANGE;
            end else begin
                n_len = r_len - LEN_W'(1);
            end
        end
    end

    always_comb begin
        o_cmd.op      = i_operation;
        o_cmd.pos     = i_position;
        o_cmd.value   = i_value;
        o_cmd.status  = status;
        o_cmd.old_len = r_len;
        o_cmd.new_len = n_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else if (o_push) begin
            r_len <= n_len;
        end
    end

endmodule

`default_nettype wire

FILE: src/pli_cmd_fifo.sv
// Short command queue between the front and back ends of the positional list.
// Depends on pli_pkg.
`default_nettype none

module pli_cmd_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire pli_pkg::t_cmd i_cmd,
    input  wire logic          i_pop,
    output pli_pkg::t_cmd      o_cmd,
    output logic               o_full,
    output logic               o_valid
);
    import pli_pkg::*;

    t_cmd              r_slot [Q_DEPTH];
    logic [Q_AW-1:0]   r_wp;
    logic [Q_AW-1:0]   r_rp;
    logic [Q_CW-1:0]   r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_cnt == Q_CW'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_slot[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + Q_AW'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + Q_AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + Q_CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - Q_CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

FILE: src/pli_back.sv
// Back end of the positional list: holds the element memory, shifts entries
// one per cycle for insert and delete, then reads out the whole list.
// Depends on pli_pkg.
`default_nettype none

module pli_back (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cmd_valid,
    input  wire pli_pkg::t_cmd             i_cmd,
    output logic                           o_cmd_pop,
    output logic                           o_strobe,
    output logic [1:0]                     o_status,
    output logic [pli_pkg::LEN_W-1:0]      o_list_length,
    output logic                           o_list_empty,
    output logic [pli_pkg::IDX_W-1:0]      o_element_index,
    output logic [pli_pkg::VAL_W-1:0]      o_element_value,
    output logic                           o_last
);
    import pli_pkg::*;

    logic [VAL_W-1:0]  mem [CAPACITY];

    t_back_state       r_state;
    t_back_state       n_state;
    t_cmd              r_cmd;
    t_cmd              n_cmd;
    logic [LEN_W-1:0]  r_cur;
    logic [LEN_W-1:0]  n_cur;
    logic [LEN_W-1:0]  r_end;
    logic [LEN_W-1:0]  n_end;
    logic              r_pend;
    logic              n_pend;
    logic [ADDR_W-1:0] r_wa;
    logic [ADDR_W-1:0] n_wa;
    logic [VAL_W-1:0]  r_rdata;
    logic              r_ov;
    logic              n_ov;
    t_status           r_o_status;
    t_status           n_o_status;
    logic [LEN_W-1:0]  r_o_len;
    logic [LEN_W-1:0]  n_o_len;
    logic              r_o_empty;
    logic              n_o_empty;
    logic [IDX_W-1:0]  r_o_idx;
    logic [IDX_W-1:0]  n_o_idx;
    logic              r_o_last;
    logic              n_o_last;

    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [VAL_W-1:0]  wr_data;
    logic [LEN_W-1:0]  dump_end;

    assign dump_end = r_cmd.new_len - LEN_W'(1);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = (i_cmd.status == ST_DONE) ? S_MOVE : S_DUMP;
                end
            end
            S_MOVE: begin
                if (r_cur == r_end) begin
                    n_state = (r_cmd.op == OP_INSERT) ? S_PUT : S_DUMP;
                end
            end
            S_PUT: begin
                n_state = S_DUMP;
            end
            S_DUMP: begin
                if (r_cmd.new_len == '0 || r_cur == dump_end) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd_pop  = 1'b0;
        n_cmd      = r_cmd;
        n_cur      = r_cur;
        n_end      = r_end;
        n_pend     = 1'b0;
        n_wa       = r_wa;
        n_ov       = 1'b0;
        n_o_status = r_o_status;
        n_o_len    = r_o_len;
        n_o_empty  = r_o_empty;
        n_o_idx    = r_o_idx;
        n_o_last   = r_o_last;
        rd_en      = 1'b0;
        rd_addr    = r_cur[ADDR_W-1:0];
        // A move issued last cycle lands now, whatever the state.
        wr_en      = r_pend;
        wr_addr    = r_wa;
        wr_data    = r_rdata;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    if (i_cmd.status != ST_DONE) begin
                        n_cur = '0;
                    end else if (i_cmd.op == OP_INSERT) begin
                        n_cur = i_cmd.old_len;
                        n_end = LEN_W'(i_cmd.pos);
                    end else begin
                        n_cur = LEN_W'(i_cmd.pos);
                        n_end = i_cmd.old_len - LEN_W'(1);
                    end
                end
            end
            S_MOVE: begin
                if (r_cur != r_end) begin
                    rd_en  = 1'b1;
                    n_pend = 1'b1;
                    n_wa   = r_cur[ADDR_W-1:0];
                    if (r_cmd.op == OP_INSERT) begin
                        n_cur   = r_cur - LEN_W'(1);
                        rd_addr = n_cur[ADDR_W-1:0];
                    end else begin
                        n_cur   = r_cur + LEN_W'(1);
                        rd_addr = n_cur[ADDR_W-1:0];
                    end
                end else begin
                    n_cur = '0;
                end
            end
            S_PUT: begin
                wr_en   = 1'b1;
                wr_addr = r_cmd.pos[ADDR_W-1:0];
                wr_data = r_cmd.value;
            end
            S_DUMP: begin
                n_ov       = 1'b1;
                n_o_status = r_cmd.status;
                n_o_len    = r_cmd.new_len;
                if (r_cmd.new_len == '0) begin
                    n_o_empty = 1'b1;
                    n_o_idx   = '0;
                    n_o_last  = 1'b1;
                end else begin
                    rd_en     = 1'b1;
                    n_o_empty = 1'b0;
                    n_o_idx   = r_cur[IDX_W-1:0];
                    n_o_last  = (r_cur == dump_end);
                    n_cur     = r_cur + LEN_W'(1);
                end
            end
            default: begin
                n_cur = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_cur      <= n_cur;
        r_end      <= n_end;
        r_wa       <= n_wa;
        r_o_status <= n_o_status;
        r_o_len    <= n_o_len;
        r_o_empty  <= n_o_empty;
        r_o_idx    <= n_o_idx;
        r_o_last   <= n_o_last;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    assign o_strobe        = r_ov;
    assign o_status        = r_o_status;
    assign o_list_length   = r_o_len;
    assign o_list_empty    = r_o_empty;
    assign o_element_index = r_o_idx;
    assign o_element_value = r_o_empty ? '0 : r_rdata;
    assign o_last          = r_o_last;

    a_empty_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_list_empty) |-> (o_last && o_element_index == '0))
        else $error("empty-list word is not a single last word");

    a_index_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_list_empty) |-> ({1'b0, o_element_index} < o_list_length))
        else $error("dumped index beyond list length");

    a_move_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> $past(r_state == S_MOVE))
        else $error("pending move write outside a shift");

endmodule

`default_nettype wire

FILE: src/positional_list_insert_delete_top.sv
// Top level of the positional list block: front end, command queue and
// back end. Depends on pli_pkg, pli_front, pli_cmd_fifo and pli_back.
//
// Use: the block keeps an ordered list of up to 32 signed 32-bit values.
// A command word (operation, position, value) is taken at a rising edge
// where start is high and busy is low. Insert puts the value at a position
// from 0 to the current length; delete removes the entry at a position
// below the length. A bad position gives status 1, an insert into a full
// list gives status 2, and the list is then left as it was.
// After every command the block dumps the list as a run of result words,
// lowest index first, each marked by o_strobe for one cycle, with o_last on
// the final word. An empty list gives one word with o_list_empty set.
// The receiver cannot stall: results come out when they are ready.
// Flow: the front end checks each word against its own copy of the
// length and places it in a two-entry queue; busy is high only while that
// queue is full. The back end picks up a command, shifts the entries one
// at a time, writes an inserted value and then dumps the list entry by
// entry; each word shows in the cycle after its dump step.
// An insert at the front of a list of 31 is the worst case.
// Reset (synchronous, active low) empties the list and the queue; the
// element memory is not cleared, only entries below the length are read.
`default_nettype none

module positional_list_insert_delete_top (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic                      i_operation,
    input  wire logic [pli_pkg::POS_W-1:0] i_position,
    input  wire logic [pli_pkg::VAL_W-1:0] i_value,
    output logic                           o_strobe,
    output logic [1:0]                     o_status,
    output logic [pli_pkg::LEN_W-1:0]      o_list_length,
    output logic                           o_list_empty,
    output logic [pli_pkg::IDX_W-1:0]      o_element_index,
    output logic [pli_pkg::VAL_W-1:0]      o_element_value,
    output logic                           o_last
);
    import pli_pkg::*;

    logic push;
    logic pop;
    logic q_full;
    logic q_valid;
    t_cmd front_cmd;
    t_cmd back_cmd;

    assign busy = q_full;

    // The front end classifies each accepted word and pushes it.
    pli_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_full      (q_full),
        .i_operation (i_operation),
        .i_position  (i_position),
        .i_value     (i_value),
        .o_push      (push),
        .o_cmd       (front_cmd)
    );

    // The queue decouples acceptance from the shifting and the dump.
    pli_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (back_cmd),
        .o_full  (q_full),
        .o_valid (q_valid)
    );

    // The back end owns the element memory and drives every result word.
    pli_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (q_valid),
        .i_cmd           (back_cmd),
        .o_cmd_pop       (pop),
        .o_strobe        (o_strobe),
        .o_status        (o_status),
        .o_list_length   (o_list_length),
        .o_list_empty    (o_list_empty),
        .o_element_index (o_element_index),
        .o_element_value (o_element_value),
        .o_last          (o_last)
    );

endmodule

`default_nettype wire
